// File: hdl/u8d_pkg.sv
// shared types and constants for the utf-8 byte stream decoder
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned DUE_W = 2;

  // byte class boundaries
  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;

  // payload masks
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  // continuation bytes still due
  localparam logic [DUE_W-1:0] DUE_NONE  = 2'd0;
  localparam logic [DUE_W-1:0] DUE_ONE   = 2'd1;
  localparam logic [DUE_W-1:0] DUE_TWO   = 2'd2;
  localparam logic [DUE_W-1:0] DUE_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_last;
  } in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_error;
    logic            string_end;
  } out_t;

  typedef struct packed {
    logic [CP_W-1:0]  accumulator;
    logic [DUE_W-1:0] bytes_due;
    logic             dropping;
  } state_t;

  // core to output stage
  typedef struct packed {
    logic emit;
    out_t data;
  } result_t;

endpackage

// File: hdl/u8d_core.sv
// decode state and single-pass byte decode logic
`timescale 1ns / 1ps

module u8d_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  u8d_pkg::in_t     item,
  output u8d_pkg::result_t result
);

  u8d_pkg::state_t state_r;
  u8d_pkg::state_t state_nxt;

  logic [u8d_pkg::CP_W-1:0]  cont_bits;
  logic [u8d_pkg::CP_W-1:0]  acc_merged;
  logic [u8d_pkg::DUE_W-1:0] due_dec;
  logic [7:0]                b;
  logic                      last;

  assign b    = item.data_byte;
  assign last = item.string_last;

  assign cont_bits = {{(u8d_pkg::CP_W - 6){1'b0}}, b[5:0] & u8d_pkg::CONT_MASK[5:0]};
  assign due_dec   = state_r.bytes_due - u8d_pkg::DUE_ONE;

  // place the six payload bits by how many bytes remain
  always_comb begin
    unique case (state_r.bytes_due)
      u8d_pkg::DUE_THREE: acc_merged = state_r.accumulator | (cont_bits << 12);
      u8d_pkg::DUE_TWO:   acc_merged = state_r.accumulator | (cont_bits << 6);
      default:            acc_merged = state_r.accumulator | cont_bits;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    result    = '0;
    if (state_r.dropping) begin
      if (last) begin
        state_nxt = '0;
      end
    end else if (state_r.bytes_due != u8d_pkg::DUE_NONE) begin
      if (due_dec == u8d_pkg::DUE_NONE) begin
        result.emit            = 1'b1;
        result.data.code_point = acc_merged;
        result.data.string_end = last;
        state_nxt              = '0;
      end else if (last) begin
        result.emit            = 1'b1;
        result.data.is_error   = 1'b1;
        result.data.string_end = 1'b1;
        state_nxt              = '0;
      end else begin
        state_nxt.accumulator = acc_merged;
        state_nxt.bytes_due   = due_dec;
      end
    end else if (b < u8d_pkg::CONT_MIN) begin
      result.emit            = 1'b1;
      result.data.code_point = {{(u8d_pkg::CP_W - 8){1'b0}}, b};
      result.data.string_end = last;
      state_nxt              = '0;
    end else if (b < u8d_pkg::LEAD2_MIN) begin
      // stray continuation byte
      result.emit            = 1'b1;
      result.data.is_error   = 1'b1;
      result.data.string_end = last;
      state_nxt              = '0;
      state_nxt.dropping     = ~last;
    end else begin
      if (b < u8d_pkg::LEAD3_MIN) begin
        state_nxt.accumulator = {{(u8d_pkg::CP_W - 11){1'b0}},
                                 b[4:0] & u8d_pkg::LEAD2_MASK[4:0], 6'b0};
        state_nxt.bytes_due   = u8d_pkg::DUE_ONE;
      end else if (b < u8d_pkg::LEAD4_MIN) begin
        state_nxt.accumulator = {{(u8d_pkg::CP_W - 16){1'b0}},
                                 b[3:0] & u8d_pkg::LEAD3_MASK[3:0], 12'b0};
        state_nxt.bytes_due   = u8d_pkg::DUE_TWO;
      end else begin
        state_nxt.accumulator = {b[2:0] & u8d_pkg::LEAD4_MASK[2:0], 18'b0};
        state_nxt.bytes_due   = u8d_pkg::DUE_THREE;
      end
      if (last) begin
        // truncated sequence
        result.emit            = 1'b1;
        result.data.is_error   = 1'b1;
        result.data.string_end = 1'b1;
        state_nxt              = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/u8d_out_stage.sv
// result register with stall handling
`timescale 1ns / 1ps

module u8d_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  u8d_pkg::result_t result,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output u8d_pkg::out_t    out_data
);

  logic          valid_r;
  logic          valid_nxt;
  u8d_pkg::out_t data_r;

  assign ready = ~valid_r | ~out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) begin
      valid_nxt = load & result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load && result.emit) begin
      data_r <= result.data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/utf8_byte_stream_decoder.sv
// top level of the lenient utf-8 byte stream decoder
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   u8d_pkg::in_t  (data_byte, string_last)
// out_      output     out_valid / out_stall u8d_pkg::out_t (code_point, is_error, string_end)
//
// one byte per cycle sustained while out_stall is low; a byte is held in the
// input register, is decoded against the state in a single pass and its result
// lands in the output register, from which it is presented
// the decode state (accumulator, bytes due, drop flag) advances as the byte
// leaves the input register, which only waits on the output register
// synchronous active-low reset clears the valid flags and the decode state
// out_stall holds the result register and backs up into in_stall

module utf8_byte_stream_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  u8d_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output u8d_pkg::out_t out_data
);

  // input register
  logic             in_valid_r;
  logic             in_valid_nxt;
  u8d_pkg::in_t     in_data_r;

  logic             out_ready;
  logic             advance;
  logic             in_take;
  u8d_pkg::result_t result;

  // the held byte moves on whenever the result register can take its outcome
  assign advance  = in_valid_r & out_ready;
  assign in_stall = in_valid_r & ~out_ready;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (advance || !in_valid_r) begin
      in_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // decode and state update
  u8d_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_data_r),
    .result  (result)
  );

  // result register; bytes with no result simply pass through
  u8d_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: sim/tb.sv
// self-checking testbench for the lenient utf-8 byte stream decoder
`timescale 1ns / 1ps

module tb;

  // quiet cycles tolerated before the run is declared hung
  localparam int unsigned HANG_LIMIT  = 2000;
  localparam int unsigned RANDOM_BYTES = 1900;
  // tail wait over the input and output registers, with some margin
  localparam int unsigned TAIL_CYCLES = 8;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  u8d_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  u8d_pkg::out_t out_data;

  utf8_byte_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predictor state, mirrors the decoder's own registers
  logic [u8d_pkg::CP_W-1:0]  acc_bits;
  logic [u8d_pkg::DUE_W-1:0] due_cnt;
  logic                      skipping;

  // results predicted but not yet seen on the output channel
  u8d_pkg::out_t pending_points[$];

  int unsigned n_bytes   = 0;
  int unsigned n_strings = 0;
  int unsigned n_points  = 0;
  int unsigned n_errors  = 0;
  int unsigned n_fail    = 0;
  int unsigned idle_cycles = 0;

  // idling mode: calm stretches have no gaps at all
  bit          in_calm       = 1'b0;
  int unsigned in_calm_left  = 0;
  bit          out_calm      = 1'b0;
  int unsigned out_calm_left = 0;
  int unsigned stall_left    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void clear_decoder();
    acc_bits = '0;
    due_cnt  = u8d_pkg::DUE_NONE;
    skipping = 1'b0;
  endfunction

  // predicts the result (if any) caused by one accepted byte
  function automatic bit decode_byte(input u8d_pkg::in_t item, output u8d_pkg::out_t res);
    logic [7:0] b;
    logic       last;
    int         shift;
    bit         produced;
    b        = item.data_byte;
    last     = item.string_last;
    res      = '0;
    produced = 1'b0;
    if (skipping) begin
      // rest of a failed string: swallowed until its last byte
      if (last) clear_decoder();
    end else if (due_cnt != u8d_pkg::DUE_NONE) begin
      // continuation: low six bits, top bits not checked
      shift    = 6 * (int'(due_cnt) - 1);
      acc_bits = acc_bits | (u8d_pkg::CP_W'(b & u8d_pkg::CONT_MASK) << shift);
      due_cnt  = due_cnt - 1'b1;
      if (due_cnt == u8d_pkg::DUE_NONE) begin
        res.code_point = acc_bits;
        res.string_end = last;
        produced       = 1'b1;
        clear_decoder();
      end else if (last) begin
        // string ended in mid-sequence
        res.is_error   = 1'b1;
        res.string_end = 1'b1;
        produced       = 1'b1;
        clear_decoder();
      end
    end else if (b < u8d_pkg::CONT_MIN) begin
      res.code_point = u8d_pkg::CP_W'(b);
      res.string_end = last;
      produced       = 1'b1;
    end else if (b < u8d_pkg::LEAD2_MIN) begin
      // continuation byte where a lead was due
      clear_decoder();
      skipping       = !last;
      res.is_error   = 1'b1;
      res.string_end = last;
      produced       = 1'b1;
    end else begin
      if (b < u8d_pkg::LEAD3_MIN) begin
        acc_bits = u8d_pkg::CP_W'(b & u8d_pkg::LEAD2_MASK) << 6;
        due_cnt  = u8d_pkg::DUE_ONE;
      end else if (b < u8d_pkg::LEAD4_MIN) begin
        acc_bits = u8d_pkg::CP_W'(b & u8d_pkg::LEAD3_MASK) << 12;
        due_cnt  = u8d_pkg::DUE_TWO;
      end else begin
        acc_bits = u8d_pkg::CP_W'(b & u8d_pkg::LEAD4_MASK) << 18;
        due_cnt  = u8d_pkg::DUE_THREE;
      end
      if (last) begin
        // lead byte that closes its string
        clear_decoder();
        res.is_error   = 1'b1;
        res.string_end = 1'b1;
        produced       = 1'b1;
      end
    end
    return produced;
  endfunction

  // one input transaction; valid stays high afterwards so back-to-back
  // bytes are never dropped and raised in the same step
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned   gap;
    u8d_pkg::out_t res;
    if (in_calm_left == 0) begin
      in_calm      = ($urandom_range(0, 2) == 0);
      in_calm_left = $urandom_range(20, 100);
    end
    in_calm_left--;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, string_last: last};
    do @(posedge clk); while (in_stall);
    n_bytes++;
    if (last) n_strings++;
    if (decode_byte('{data_byte: b, string_last: last}, res)) pending_points.push_back(res);
  endtask

  // plain ascii, including nul and the top one-byte value
  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // complete sequences of two to four bytes, a 0xff lead and
  // continuation bytes whose top bits are wrong
  task automatic test_multibyte();
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // stray continuation: one error, rest of the string dropped; then a stray that ends its string
  task automatic test_stray_continuation();
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hBF, 1'b1);
  endtask

  // strings that end with bytes still due
  task automatic test_truncated();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b1);
    send_byte(8'hF0, 1'b1);
  endtask

  // random strings: mostly well formed, some broken, some pure noise
  task automatic test_random_text();
    int unsigned kind, n_chars, len, nb, stray_at;
    logic [7:0]  bt;
    bit          final_char;
    while (n_bytes < RANDOM_BYTES + 24) begin
      kind    = $urandom_range(0, 99);
      n_chars = $urandom_range(1, 10);
      if (kind >= 92) begin
        for (int k = 0; k < n_chars; k++)
          send_byte(8'($urandom_range(0, 255)), k == n_chars - 1);
      end else begin
        stray_at = (kind >= 86) ? $urandom_range(0, n_chars - 1) : n_chars;
        for (int c = 0; c < n_chars; c++) begin
          final_char = (c == n_chars - 1);
          if (c == stray_at) send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
          len = $urandom_range(1, 4);
          nb  = len;
          if (kind >= 80 && kind < 86 && final_char && len > 1) nb = $urandom_range(1, len - 1);
          for (int k = 0; k < nb; k++) begin
            if (k != 0) begin
              bt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(8'h80, 8'hBF));
            end else begin
              case (len)
                1:       bt = 8'($urandom_range(8'h00, 8'h7F));
                2:       bt = 8'($urandom_range(8'hC0, 8'hDF));
                3:       bt = 8'($urandom_range(8'hE0, 8'hEF));
                default: bt = 8'($urandom_range(8'hF0, 8'hFF));
              endcase
            end
            send_byte(bt, final_char && k == nb - 1);
          end
        end
      end
    end
  endtask

  // receiver back-pressure in runs of random length
  always @(posedge clk) begin
    if (out_calm_left == 0) begin
      out_calm      = ($urandom_range(0, 2) == 0);
      out_calm_left = $urandom_range(30, 150);
    end
    out_calm_left--;
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap(out_calm);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // compares every output transaction with the oldest prediction
  always @(posedge clk) begin
    u8d_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected result: code_point %0h is_error %0b string_end %0b",
               out_data.code_point, out_data.is_error, out_data.string_end);
        n_fail++;
      end else begin
        want = pending_points.pop_front();
        if (want.is_error) n_errors++;
        else n_points++;
        if (out_data.code_point !== want.code_point) begin
          $error("code_point: expected %0h, got %0h", want.code_point, out_data.code_point);
          n_fail++;
        end
        if (out_data.is_error !== want.is_error) begin
          $error("is_error: expected %0b, got %0b", want.is_error, out_data.is_error);
          n_fail++;
        end
        if (out_data.string_end !== want.string_end) begin
          $error("string_end: expected %0b, got %0b", want.string_end, out_data.string_end);
          n_fail++;
        end
      end
    end
  end

  // hang detection: no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[utf8_byte_stream_decoder] ERROR");
        $finish;
      end
    end
  end

  initial begin
    clear_decoder();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ascii();
    test_multibyte();
    test_stray_continuation();
    test_truncated();
    test_random_text();

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d strings: %0d code points, %0d error results",
             n_bytes, n_strings, n_points, n_errors);
    $display("%0d mismatches", n_fail);
    if (n_fail == 0) begin
      $display("[utf8_byte_stream_decoder] OK");
    end else begin
      $display("[utf8_byte_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/u8d_pkg.sv
hdl/u8d_core.sv
hdl/u8d_out_stage.sv
hdl/utf8_byte_stream_decoder.sv
sim/tb.sv
